FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define CIS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/cis_pkg.sv
// Shared types, constants and helpers of the substring search block.
`default_nettype none

package cis_pkg;

  localparam int MAX_PATTERN_DEF  = 32;
  localparam int OFFSET_WIDTH_DEF = 16;

  // Pattern storage in the register file: four 64-bit registers of 8 bytes.
  localparam int REG_BYTES     = 32;
  localparam int LEN_REG_W     = 6;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;
  localparam int RES_OFFSET_W  = 16;

  // Register indexes.
  localparam logic [2:0] REG_LENGTH = 3'd0;
  localparam logic [2:0] REG_PAT0   = 3'd1;
  localparam logic [2:0] REG_PAT1   = 3'd2;
  localparam logic [2:0] REG_PAT2   = 3'd3;
  localparam logic [2:0] REG_PAT3   = 3'd4;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic                    match_here;
    logic                    found;
    logic [RES_OFFSET_W-1:0] match_offset;
    logic                    last;
  } res_t;

  // Map upper case ASCII letters onto lower case, leave other bytes alone.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/cis_compare.sv
// Parallel case-folded compare of the text window against the pattern.
`default_nettype none

module cis_compare #(
  parameter int MAX_PATTERN = cis_pkg::MAX_PATTERN_DEF,
  localparam int LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN-1:0][7:0] window_i,   // newest byte at index 0
  input  logic [MAX_PATTERN-1:0][7:0] pattern_i,  // byte 0 first
  input  logic [LenW-1:0]             len_i,      // already clamped to MAX_PATTERN
  output logic                        hit_o
);
  import cis_pkg::*;

  localparam int IdxW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PatDepth = 2 ** IdxW;

  logic [PatDepth-1:0][7:0]    pat_ext;
  logic [MAX_PATTERN-1:0]      pos_ok;

  always_comb begin
    for (int k = 0; k < PatDepth; k++) begin
      pat_ext[k] = (k < MAX_PATTERN) ? fold_lower(pattern_i[k % MAX_PATTERN]) : 8'h00;
    end
  end

  // Window byte j lines up with pattern byte len-1-j; bytes past the length pass.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      logic [LenW-1:0] idx;
      idx = len_i - LenW'(j) - LenW'(1);
      pos_ok[j] = (LenW'(j) >= len_i) ||
                  (fold_lower(window_i[j]) == pat_ext[idx[IdxW-1:0]]);
    end
  end

  assign hit_o = (len_i != '0) && (&pos_ok);

endmodule

`default_nettype wire

FILE: design/case_insensitive_substring_search.sv
// Top level: register file, text window, match tracking and output skid.
// Each result is registered into the output stage or the skid entry.
// Throughput: one byte per cycle unless in_stall_o; the window compare is
// combinational logic between the window register and the result register.
// A two-entry output buffer holds results while the output side stalls.
// Reset (asynchronous, active low) clears registers, window and counters.
`default_nettype none

`include "assert_macros.svh"

module case_insensitive_substring_search #(
  parameter int MAX_PATTERN  = cis_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_WIDTH = cis_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cis_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cis_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cis_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  // text input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_of_text_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            match_here_o,
  output logic                            found_o,
  output logic [cis_pkg::RES_OFFSET_W-1:0] match_offset_o,
  output logic                            result_last_o
);
  import cis_pkg::*;

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam int ExtW = (OFFSET_WIDTH > RES_OFFSET_W) ? OFFSET_WIDTH : RES_OFFSET_W;
  localparam logic [OFFSET_WIDTH-1:0] PosMax = '1;

  // ---------------- configuration registers ----------------
  logic [LEN_REG_W-1:0]   len_q;
  logic [CFG_DATA_W-1:0]  pat_q [4];
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      for (int r = 0; r < 4; r++) pat_q[r] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LENGTH: len_q    <= pwdata[LEN_REG_W-1:0];
        REG_PAT0:   pat_q[0] <= pwdata;
        REG_PAT1:   pat_q[1] <= pwdata;
        REG_PAT2:   pat_q[2] <= pwdata;
        REG_PAT3:   pat_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LENGTH: prdata = CFG_DATA_W'(len_q);
      REG_PAT0:   prdata = pat_q[0];
      REG_PAT1:   prdata = pat_q[1];
      REG_PAT2:   prdata = pat_q[2];
      REG_PAT3:   prdata = pat_q[3];
      default:    prdata = '0;
    endcase
  end

  // ---------------- pattern and length ----------------
  logic [4*CFG_DATA_W-1:0]      pat_flat;
  logic [MAX_PATTERN-1:0][7:0]  pattern;
  logic [LenW-1:0]              len_eff;

  assign pat_flat = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pattern[i] = (i < REG_BYTES) ? pat_flat[(i % REG_BYTES)*8 +: 8] : 8'h00;
    end
  end

  // Clamp the length to the window depth.
  always_comb begin
    if (7'(len_q) > 7'(MAX_PATTERN)) len_eff = LenW'(MAX_PATTERN);
    else                             len_eff = LenW'(len_q);
  end

  // ---------------- window and search state ----------------
  logic [MAX_PATTERN-1:0][7:0]  win_q, win_shift;
  logic [OFFSET_WIDTH-1:0]      pos_q;
  logic                         seen_q;
  logic [OFFSET_WIDTH-1:0]      first_q;
  logic                         in_accept;
  logic                         hit;
  logic                         here;
  logic [OFFSET_WIDTH:0]        pos_inc;
  logic [OFFSET_WIDTH:0]        start_full;
  logic                         seen_d;
  logic [OFFSET_WIDTH-1:0]      first_d;
  logic [ExtW-1:0]              first_ext;
  res_t                         res_new;

  always_comb begin
    win_shift[0] = text_byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) win_shift[k] = win_q[k-1];
  end

  cis_compare #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_compare (
    .window_i (win_shift),
    .pattern_i(pattern),
    .len_i    (len_eff),
    .hit_o    (hit)
  );

  assign pos_inc    = (OFFSET_WIDTH+1)'(pos_q) + (OFFSET_WIDTH+1)'(1);
  // No match until enough bytes of this text have come in.
  assign here       = hit && (pos_inc >= (OFFSET_WIDTH+1)'(len_eff));
  assign start_full = pos_inc - (OFFSET_WIDTH+1)'(len_eff);
  assign seen_d     = seen_q || here;
  assign first_d    = (here && !seen_q) ? start_full[OFFSET_WIDTH-1:0] : first_q;
  assign first_ext  = ExtW'(first_d);

  always_comb begin
    res_new.match_here = here;
    res_new.last       = end_of_text_i;
    if (len_eff == '0) begin
      res_new.found        = 1'b1;
      res_new.match_offset = '0;
    end else begin
      res_new.found        = seen_d;
      res_new.match_offset = first_ext[RES_OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
    end else if (in_accept) begin
      if (end_of_text_i) begin
        // close the text: drop window and counters
        win_q   <= '0;
        pos_q   <= '0;
        seen_q  <= 1'b0;
        first_q <= '0;
      end else begin
        win_q   <= win_shift;
        pos_q   <= (pos_q < PosMax) ? pos_inc[OFFSET_WIDTH-1:0] : pos_q;
        seen_q  <= seen_d;
        first_q <= first_d;
      end
    end
  end

  // ---------------- output register with skid entry ----------------
  logic  out_valid_q, skid_valid_q;
  res_t  out_q, skid_q;
  logic  out_take;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) out_valid_q  <= 1'b1;
      else                          skid_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_accept) begin
      // advance into the output stage when it frees up, else park in the skid
      if (!out_valid_q || out_take) out_q  <= res_new;
      else                          skid_q <= res_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_here_o   = out_q.match_here;
  assign found_o        = out_q.found;
  assign match_offset_o = out_q.match_offset;
  assign result_last_o  = out_q.last;

  // ---------------- assertions ----------------
  `CIS_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q,
              "skid entry held while output stage is empty")
  `CIS_ASSERT_NEXT(a_skid_kept, skid_valid_q && out_stall_i, skid_valid_q && out_valid_q,
                   "parked transaction lost while output stalled")
  `CIS_ASSERT_NEXT(a_eot_clears, in_accept && end_of_text_i,
                   pos_q == '0 && !seen_q && first_q == '0,
                   "text state not cleared after end of text")
  `CIS_ASSERT(a_seen_has_match, !seen_q || len_eff == '0 || pos_q != '0,
              "match recorded before any byte of the text")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench of the case-insensitive substring search: directed and random texts against a predictor.
module tb;
  import cis_pkg::*;

  localparam int WIN = MAX_PATTERN_DEF;
  localparam int POSW = OFFSET_WIDTH_DEF;
  localparam logic [POSW-1:0] POS_SAT = '1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_MAX = 16;
  localparam int RANDOM_BYTES = 1500;
  localparam logic [7:0] LOWER_A = CH_UPPER_A + CASE_DELTA;
  localparam logic [7:0] LOWER_Z = CH_UPPER_Z + CASE_DELTA;
  localparam logic [7:0] EDGE_BYTES [8] = '{8'h00, 8'h40, 8'h41, 8'h5a, 8'h5b, 8'h60, 8'h7b,
                                             8'hff};

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            text_byte_i = '0;
  logic                  end_of_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  match_here_o;
  logic                  found_o;
  logic [RES_OFFSET_W-1:0] match_offset_o;
  logic                  result_last_o;

  // predictor copy of configuration and search state
  logic [LEN_REG_W-1:0] pat_len;
  logic [63:0]          pat_reg [4];
  logic [7:0]           win [WIN];
  logic [POSW-1:0]      pos;
  logic                 seen;
  logic [POSW-1:0]      first_off;

  text_item_t pending_text[$];
  res_t       expected_scan[$];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         errors = 0;
  logic       byte_taken = 1'b0;
  int         send_wait = 0;
  int         stall_wait = 0;
  int         send_gap_max = 0;
  int         stall_max = 0;

  case_insensitive_substring_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_here_o   (match_here_o),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .result_last_o  (result_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_DELTA) : c;
  endfunction

  function automatic void clear_text();
    foreach (win[k]) win[k] = '0;
    pos = '0;
    seen = 1'b0;
    first_off = '0;
  endfunction

  // Shift one byte in, compare the window against the pattern, update first-match tracking.
  function automatic res_t scan_byte(input logic [7:0] ch, input logic eot);
    res_t r;
    int   n;
    logic hit;
    n = (pat_len > WIN) ? WIN : int'(pat_len);
    for (int k = WIN - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = ch;
    hit = 1'b0;
    if (n > 0 && int'(pos) + 1 >= n) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (to_lower(win[n-1-k]) != to_lower(pat_reg[k/8][(k%8)*8 +: 8])) hit = 1'b0;
      end
    end
    if (hit && !seen) begin
      seen = 1'b1;
      first_off = POSW'(int'(pos) + 1 - n);
    end
    r.match_here = hit;
    r.found = (n == 0) ? 1'b1 : seen;
    r.match_offset = (n == 0 || !seen) ? '0 : first_off[RES_OFFSET_W-1:0];
    r.last = eot;
    if (pos != POS_SAT) pos++;
    if (eot) clear_text();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sender: hold a stalled transaction, otherwise wait out the gap and advance.
  always @(negedge clk_i) begin : drive_text
    text_item_t cur;
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      byte_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        in_valid_i <= 1'b0;
      end else if (pending_text.size() > 0) begin
        cur = pending_text.pop_front();
        text_byte_i <= cur.ch;
        end_of_text_i <= cur.eot;
        in_valid_i <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall for the number of cycles drawn at the last transaction.
  always @(negedge clk_i) begin
    if (stall_wait > 0) begin
      stall_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_scan.push_back(scan_byte(text_byte_i, end_of_text_i));
        bytes_taken++;
        byte_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        stall_wait = $urandom_range(0, stall_max);
        if (expected_scan.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual match_here %0b found %0b offset %0d",
                   $time, match_here_o, found_o, match_offset_o);
        end else begin
          want = expected_scan.pop_front();
          check_field("match_here", want.match_here, match_here_o);
          check_field("found", want.found, found_o);
          check_field("match_offset", want.match_offset, match_offset_o);
          check_field("result_last", want.last, result_last_o);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("case_insensitive_substring_search verification failed");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk_i); while (bytes_taken != bytes_queued || expected_scan.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LENGTH: pat_len = value[LEN_REG_W-1:0];
      REG_PAT0:   pat_reg[0] = value;
      REG_PAT1:   pat_reg[1] = value;
      REG_PAT2:   pat_reg[2] = value;
      REG_PAT3:   pat_reg[3] = value;
      default: ;
    endcase
  endtask

  // Drain first, then write length and all four pattern registers.
  task automatic load_pattern(input int len, input logic [255:0] bytes);
    wait_drained();
    write_reg(REG_LENGTH, 64'(len));
    write_reg(REG_PAT0, bytes[63:0]);
    write_reg(REG_PAT1, bytes[127:64]);
    write_reg(REG_PAT2, bytes[191:128]);
    write_reg(REG_PAT3, bytes[255:192]);
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic eot);
    text_item_t it;
    it.ch = ch;
    it.eot = eot;
    pending_text.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = to_lower(c);
    if (lc >= LOWER_A && lc <= LOWER_Z && $urandom_range(0, 1) == 1) return c ^ CASE_DELTA;
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1: c = flip_case(CH_UPPER_A + 8'($urandom_range(0, 25)));
      2: c = EDGE_BYTES[$urandom_range(0, 7)];
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Build one text from whole pattern copies, prefixes and noise, case flipped at random.
  task automatic make_text(input int n_eff, input logic [255:0] pat, input logic close);
    logic [7:0] chars[$];
    int         total;
    int         seg;
    int         cut;
    total = $urandom_range(1, 2 * n_eff + 12);
    while (chars.size() < total) begin
      seg = $urandom_range(0, 9);
      if (n_eff > 0 && seg < 4) cut = n_eff;
      else if (n_eff > 1 && seg < 6) cut = $urandom_range(1, n_eff - 1);
      else cut = 0;
      if (cut > 0) begin
        for (int k = 0; k < cut; k++) chars.push_back(flip_case(pat[8*k +: 8]));
      end else begin
        repeat ($urandom_range(1, 4)) chars.push_back(noise_byte());
      end
    end
    foreach (chars[i]) send_byte(chars[i], close && i == chars.size() - 1);
  endtask

  initial begin : stimulus
    logic [255:0] pat;
    int           len;
    int           n_eff;
    int           texts;
    int           fill;
    string        word;
    pat_len = '0;
    foreach (pat_reg[k]) pat_reg[k] = '0;
    clear_text();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty pattern straight out of reset: found on every byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);

    // byte 0 is the lowest, so the literal reads reversed; short text, then a match
    load_pattern(3, 256'("cBa"));
    send_byte("A", 1'b1);
    word = "xAbCabc";
    foreach (word[i]) send_byte(word[i], i == 6);

    // zero byte in the pattern, and non-letters that differ only in the case bit
    load_pattern(5, 256'({8'h7b, 8'h60, 8'h5b, 8'h40, 8'h00}));
    send_byte(8'h00, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h5b, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h7b, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5b, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7b, 1'b1);

    while (bytes_queued < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 32;
        2: len = $urandom_range(33, 63);
        3: len = 1;
        default: len = $urandom_range(2, 10);
      endcase
      fill = $urandom_range(0, 7);
      for (int k = 0; k < 32; k++) begin
        pat[8*k +: 8] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : noise_byte();
      end
      load_pattern(len, pat);
      case ($urandom_range(0, 3))
        0: begin send_gap_max = 0; stall_max = 0; end
        1: begin send_gap_max = IDLE_MAX; stall_max = 0; end
        2: begin send_gap_max = 0; stall_max = IDLE_MAX; end
        default: begin send_gap_max = IDLE_MAX; stall_max = IDLE_MAX; end
      endcase
      n_eff = (len > WIN) ? WIN : len;
      texts = $urandom_range(2, 6);
      // leave the last text open now and then so the next setting lands mid-text
      for (int t = 0; t < texts; t++) begin
        make_text(n_eff, pat, t < texts - 1 || $urandom_range(0, 3) != 0);
      end
    end

    // mixed-case match in the closing text of the run
    load_pattern(3, 256'("Z@q"));
    send_gap_max = 0;
    stall_max = 0;
    send_byte("Q", 1'b0);
    send_byte("@", 1'b0);
    send_byte("z", 1'b1);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && expected_scan.size() == 0) begin
      $display("case_insensitive_substring_search verification clean");
    end else begin
      $display("case_insensitive_substring_search verification failed");
    end
    $finish;
  end

endmodule
